FILE: hdl/servo_instruction_packet_framer_core_macros.svh
// Assertion macros used by the servo packet framer RTL.
`ifndef SERVO_INSTRUCTION_PACKET_FRAMER_CORE_MACROS_SVH
`define SERVO_INSTRUCTION_PACKET_FRAMER_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during rst.
`define SIPF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off during rst.
`define SIPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SIPF_ASSERT_IMPL(lbl, ante, cons, msg)
`define SIPF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/sipf_pkg.sv
// Types and constants of the servo instruction packet framer.
`default_nettype none
package sipf_pkg;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic CFG_SECOND_MODEL = 1'b0;
  localparam logic CFG_FIRST_UNUSED = 1'b1;

  localparam logic [2:0] SECOND_MODEL_RESET = 3'd4;
  localparam logic [3:0] FIRST_UNUSED_RESET = 4'd5;

  localparam int PKT_BYTES  = 13;
  localparam int READ_BYTES = 8;
  localparam logic [3:0] WRITE_LEN = 4'd13;
  localparam logic [3:0] READ_LEN  = 4'd8;

  localparam logic [7:0] HDR_BYTE     = 8'hFF;
  localparam logic [7:0] LEN_READ     = 8'h04;
  localparam logic [7:0] LEN_WRITE    = 8'h09;
  localparam logic [7:0] INS_READ     = 8'h02;
  localparam logic [7:0] INS_WRITE    = 8'h03;
  localparam logic [7:0] ADDR_PRESENT = 8'h38;
  localparam logic [7:0] ADDR_GOAL    = 8'h2A;
  localparam logic [7:0] READ_COUNT   = 8'h04;

  // First scale: trunc((A*568175 + FIRST_OFS) / (2^14 * 625))
  localparam logic signed [20:0] FIRST_MUL = 21'sd568175;
  localparam logic signed [36:0] FIRST_OFS = 37'sd5375941632;
  localparam int FIRST_SHIFT = 14;
  localparam logic [9:0]  DIV_RES = 10'd625;
  localparam logic [20:0] RECIP   = 21'd1717986;  // floor(2^30 / 625)
  localparam int RECIP_SHIFT = 30;

  // Second scale: trunc((A*325 + SECOND_OFS) / 2^11)
  localparam logic signed [9:0]  SECOND_MUL   = 10'sd325;
  localparam logic signed [24:0] SECOND_OFS   = 25'sd4167680;
  localparam logic signed [24:0] SECOND_ROUND = 25'sd2047;
  localparam int SECOND_SHIFT = 11;

  typedef logic [7:0] octet_t;
  typedef octet_t [PKT_BYTES-1:0] packet_t;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  joint;
    logic [15:0] speed;
    logic        unused;
    logic        second;
  } side_t;

endpackage
`default_nettype wire

FILE: hdl/sipf_scale.sv
// Four-stage position scaling pipeline for both servo scales.
`default_nettype none
module sipf_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [15:0]   in_angle,
  input  sipf_pkg::side_t      in_side,
  output logic                 out_valid,
  output sipf_pkg::side_t      out_side,
  output logic [15:0]          out_pos1,
  output logic [15:0]          out_pos2
);
  import sipf_pkg::*;

  logic               b_valid, c_valid, d_valid, e_valid;
  side_t              b_side, c_side, d_side, e_side;
  logic signed [36:0] b_p1;
  logic signed [24:0] b_m2;
  logic               c_neg1, d_neg1;
  logic [20:0]        c_u1, d_u1;
  logic [15:0]        c_pos2, d_pos2, e_pos2;
  logic [11:0]        d_q0;
  logic [15:0]        e_pos1;

  logic signed [36:0] p1, t1;
  logic signed [24:0] m2, t2, adj2, sh2;
  logic [36:0]        mag1;
  logic [41:0]        prod;
  logic [20:0]        back, rem;
  logic [11:0]        q1;

  always_comb begin
    p1   = 37'(in_angle) * 37'(FIRST_MUL);
    m2   = 25'(in_angle) * 25'(SECOND_MUL);
    t1   = b_p1 + FIRST_OFS;
    mag1 = t1[36] ? (37'd0 - 37'(t1)) : 37'(t1);
    t2   = b_m2 + SECOND_OFS;
    // round toward zero when negative
    adj2 = t2 + (t2[24] ? SECOND_ROUND : 25'sd0);
    sh2  = adj2 >>> SECOND_SHIFT;
    prod = 42'(c_u1) * 42'(RECIP);
    back = 21'(d_q0) * 21'(DIV_RES);
    rem  = d_u1 - back;
    q1   = d_q0 + {11'd0, (rem >= 21'(DIV_RES))};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else if (en) begin
      b_valid <= in_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
    end
    if (en) begin
      b_side <= in_side;
      b_p1   <= p1;
      b_m2   <= m2;
      c_side <= b_side;
      c_neg1 <= t1[36];
      c_u1   <= mag1[FIRST_SHIFT+20:FIRST_SHIFT];
      c_pos2 <= sh2[15:0];
      d_side <= c_side;
      d_neg1 <= c_neg1;
      d_u1   <= c_u1;
      d_pos2 <= c_pos2;
      d_q0   <= prod[RECIP_SHIFT+11:RECIP_SHIFT];
      e_side <= d_side;
      e_pos2 <= d_pos2;
      e_pos1 <= d_neg1 ? (16'd0 - {4'd0, q1}) : {4'd0, q1};
    end
  end

  assign out_valid = e_valid;
  assign out_side  = e_side;
  assign out_pos1  = e_pos1;
  assign out_pos2  = e_pos2;

endmodule
`default_nettype wire

FILE: hdl/sipf_packer.sv
// Packet assembly stage: byte order, zeroing of unused joints, checksum.
`default_nettype none
module sipf_packer (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  sipf_pkg::side_t   in_side,
  input  logic [15:0]       in_pos1,
  input  logic [15:0]       in_pos2,
  output logic              out_valid,
  output logic              out_opcode,
  output sipf_pkg::packet_t out_pkt
);
  import sipf_pkg::*;

  logic        f_valid;
  logic        f_opcode;
  packet_t     f_pkt;
  packet_t     pkt;
  logic [15:0] pos, spd;
  octet_t      id, p0, p1, s0, s1, sum;

  always_comb begin
    id  = 8'(in_side.joint) + 8'd1;
    pos = in_side.unused ? 16'd0 : (in_side.second ? in_pos2 : in_pos1);
    spd = in_side.unused ? 16'd0 : in_side.speed;
    // second model sends low byte first
    if (in_side.second && !in_side.unused) begin
      p0 = pos[7:0];
      p1 = pos[15:8];
      s0 = spd[7:0];
      s1 = spd[15:8];
    end else begin
      p0 = pos[15:8];
      p1 = pos[7:0];
      s0 = spd[15:8];
      s1 = spd[7:0];
    end
    pkt    = '0;
    pkt[0] = HDR_BYTE;
    pkt[1] = HDR_BYTE;
    pkt[2] = id;
    case (in_side.opcode)
      OP_READ: begin
        pkt[3] = LEN_READ;
        pkt[4] = INS_READ;
        pkt[5] = ADDR_PRESENT;
        pkt[6] = READ_COUNT;
        sum    = id + LEN_READ + INS_READ + ADDR_PRESENT + READ_COUNT;
        pkt[READ_BYTES-1] = ~sum;
      end
      default: begin
        pkt[3]  = LEN_WRITE;
        pkt[4]  = INS_WRITE;
        pkt[5]  = ADDR_GOAL;
        pkt[6]  = p0;
        pkt[7]  = p1;
        pkt[10] = s0;
        pkt[11] = s1;
        sum     = id + LEN_WRITE + INS_WRITE + ADDR_GOAL + p0 + p1 + s0 + s1;
        pkt[PKT_BYTES-1] = ~sum;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= in_valid;
    end
    if (en) begin
      f_opcode <= in_side.opcode;
      f_pkt    <= pkt;
    end
  end

  assign out_valid  = f_valid;
  assign out_opcode = f_opcode;
  assign out_pkt    = f_pkt;

endmodule
`default_nettype wire

FILE: hdl/sipf_serial.sv
// Byte serialiser: shifts one packet out, one byte per item.
`default_nettype none
`include "servo_instruction_packet_framer_core_macros.svh"
module sipf_serial (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  input  logic              load_opcode,
  input  sipf_pkg::packet_t load_pkt,
  output logic              load_ready,
  output logic              pkt_valid,
  input  logic              pkt_stall,
  output logic [7:0]        packet_byte,
  output logic              last_byte
);
  import sipf_pkg::*;

  packet_t    sh;
  logic [3:0] left;
  logic       take, load;

  assign pkt_valid   = (left != 4'd0);
  assign take        = pkt_valid && !pkt_stall;
  assign last_byte   = (left == 4'd1);
  // take the next packet as the checksum byte leaves
  assign load_ready  = !pkt_valid || (take && last_byte);
  assign load        = load_valid && load_ready;
  assign packet_byte = sh[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 4'd0;
    end else if (load) begin
      left <= (load_opcode == OP_WRITE) ? WRITE_LEN : READ_LEN;
    end else if (take) begin
      left <= left - 4'd1;
    end
    if (load) begin
      sh <= load_pkt;
    end else if (take) begin
      sh <= {8'h00, sh[PKT_BYTES-1:1]};
    end
  end

  `SIPF_ASSERT_IMPL(a_left_range, pkt_valid, left <= WRITE_LEN, "byte count out of range")
  `SIPF_ASSERT_IMPL(a_load_on_end, load && pkt_valid, take && last_byte, "load mid packet")
  `SIPF_ASSERT_NEXT(a_keep_going, take && !last_byte, pkt_valid, "packet cut short")
  `SIPF_ASSERT_NEXT(a_drain, take && last_byte && !load, !pkt_valid, "stray byte after end")

endmodule
`default_nettype wire

FILE: hdl/servo_instruction_packet_framer_core.sv
// Top level of the servo instruction packet framer.
//
// Command channel (cmd_valid / cmd_stall): one item per joint command,
// opcode read or write goal, joint index, goal angle (Q3.12) and speed.
// Packet channel (pkt_valid / pkt_stall): one packet byte per item, the
// checksum byte flagged by last_byte. A read request gives 8 bytes, a
// write goal 13.
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0
// selects the joint on the second servo scale, index 1 the first unused
// joint. Write only while the block is idle.
// A command passes a six-stage pipeline (input register, four scaling
// stages, assembly) and then a byte shifter, which presents the first
// byte of its packet once loaded. Throughput is one packet byte per
// cycle while pkt_stall is low, so the single output byte lane sets
// the rate at which commands can be taken.
// Reset clears all valid flags and loads the configuration defaults.
// A stall on the packet channel holds the current byte; the pipeline runs
// until assembly holds a packet, then it and the command channel stall.
`default_nettype none
module servo_instruction_packet_framer_core #(
  parameter int JOINT_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic               opcode,
  input  logic [2:0]         joint_index,
  input  logic signed [15:0] goal_angle,
  input  logic [15:0]        goal_speed,
  output logic               pkt_valid,
  input  logic               pkt_stall,
  output logic [7:0]         packet_byte,
  output logic               last_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data
);
  import sipf_pkg::*;

  logic               [2:0] second_model;
  logic               [3:0] first_unused;
  logic               en;
  logic               a_valid;
  logic signed [15:0] a_angle;
  side_t              a_side, side_in;
  logic               e_valid;
  side_t              e_side;
  logic [15:0]        e_pos1, e_pos2;
  logic               f_valid, f_opcode, ser_ready;
  packet_t            f_pkt;

  assign cfg_ready = 1'b1;
  // advance the whole pipeline when the last stage can drain
  assign en        = !f_valid || ser_ready;
  assign cmd_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      second_model <= SECOND_MODEL_RESET;
      first_unused <= FIRST_UNUSED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SECOND_MODEL: second_model <= cfg_data[2:0];
        CFG_FIRST_UNUSED: first_unused <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    side_in.opcode = opcode;
    side_in.joint  = joint_index;
    side_in.speed  = goal_speed;
    side_in.unused = ({1'b0, joint_index} >= first_unused) ||
                     ({29'd0, joint_index} >= 32'(JOINT_SLOTS));
    side_in.second = (joint_index == second_model);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= cmd_valid;
    end
    if (en) begin
      a_angle <= goal_angle;
      a_side  <= side_in;
    end
  end

  sipf_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_valid),
    .in_angle  (a_angle),
    .in_side   (a_side),
    .out_valid (e_valid),
    .out_side  (e_side),
    .out_pos1  (e_pos1),
    .out_pos2  (e_pos2)
  );

  sipf_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (e_valid),
    .in_side    (e_side),
    .in_pos1    (e_pos1),
    .in_pos2    (e_pos2),
    .out_valid  (f_valid),
    .out_opcode (f_opcode),
    .out_pkt    (f_pkt)
  );

  sipf_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (f_valid),
    .load_opcode (f_opcode),
    .load_pkt    (f_pkt),
    .load_ready  (ser_ready),
    .pkt_valid   (pkt_valid),
    .pkt_stall   (pkt_stall),
    .packet_byte (packet_byte),
    .last_byte   (last_byte)
  );

endmodule
`default_nettype wire

FILE: tb/sv/sipf_packet_checker.sv
// Checker for the servo packet framer: predicts each packet and compares the byte stream.
module sipf_packet_checker #(
  parameter int JOINT_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic               cmd_stall,
  input  logic               opcode,
  input  logic [2:0]         joint_index,
  input  logic signed [15:0] goal_angle,
  input  logic [15:0]        goal_speed,
  input  logic               pkt_valid,
  input  logic               pkt_stall,
  input  logic [7:0]         packet_byte,
  input  logic               last_byte,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sipf_pkg::*;

  typedef struct packed {
    octet_t value;
    logic   last;
  } bus_beat_t;

  bus_beat_t  bytes_due[$];
  logic [2:0] model2_joint;
  logic [3:0] unused_from;

  // trunc((a + 2.09) * 227.27 + 50), wrapped to 16 bits
  function automatic logic [15:0] first_scale_pos(logic signed [15:0] angle);
    longint a;
    longint n;
    a = angle;
    n = (a * 100 + 209 * 4096) * 22727 + longint'(50) * 40960000;
    return 16'(n / 40960000);
  endfunction

  // trunc((a + 3.1) * 650 + 20), wrapped to 16 bits
  function automatic logic [15:0] second_scale_pos(logic signed [15:0] angle);
    longint a;
    longint n;
    a = angle;
    n = (a * 10 + 31 * 4096) * 650 + longint'(20) * 40960;
    return 16'(n / 40960);
  endfunction

  task automatic frame_packet(logic op, logic [2:0] joint, logic signed [15:0] angle,
                              logic [15:0] speed);
    octet_t      pkt [PKT_BYTES];
    int          len;
    octet_t      sum;
    logic [15:0] pos;
    pkt[0] = HDR_BYTE;
    pkt[1] = HDR_BYTE;
    pkt[2] = {5'd0, joint} + 8'd1;
    if (op == OP_READ) begin
      pkt[3] = LEN_READ;
      pkt[4] = INS_READ;
      pkt[5] = ADDR_PRESENT;
      pkt[6] = READ_COUNT;
      len = READ_BYTES;
    end else begin
      pkt[3] = LEN_WRITE;
      pkt[4] = INS_WRITE;
      pkt[5] = ADDR_GOAL;
      pkt[8] = 8'h00;
      pkt[9] = 8'h00;
      // an unused joint wins over the second-scale selection
      if ({1'b0, joint} >= unused_from || int'(joint) >= JOINT_SLOTS) begin
        pkt[6]  = 8'h00;
        pkt[7]  = 8'h00;
        pkt[10] = 8'h00;
        pkt[11] = 8'h00;
      end else if (joint == model2_joint) begin
        pos = second_scale_pos(angle);
        pkt[6]  = pos[7:0];
        pkt[7]  = pos[15:8];
        pkt[10] = speed[7:0];
        pkt[11] = speed[15:8];
      end else begin
        pos = first_scale_pos(angle);
        pkt[6]  = pos[15:8];
        pkt[7]  = pos[7:0];
        pkt[10] = speed[15:8];
        pkt[11] = speed[7:0];
      end
      len = PKT_BYTES;
    end
    sum = 8'h00;
    for (int k = 2; k < len - 1; k++) sum += pkt[k];
    pkt[len - 1] = 8'hFF - sum;
    for (int k = 0; k < len; k++) bytes_due.push_back('{pkt[k], k == len - 1});
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    bus_beat_t due;
    if (rst) begin
      model2_joint = SECOND_MODEL_RESET;
      unused_from  = FIRST_UNUSED_RESET;
      bytes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SECOND_MODEL) model2_joint = cfg_data[2:0];
        else                               unused_from  = cfg_data;
      end
      if (pkt_valid && !pkt_stall) begin
        if (bytes_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected byte %02h last=%0b", $realtime, packet_byte, last_byte);
        end else begin
          due = bytes_due.pop_front();
          if (packet_byte !== due.value || last_byte !== due.last) begin
            errors++;
            if (errors <= 10)
              $display("%0t: byte mismatch: expected %02h last=%0b, got %02h last=%0b",
                       $realtime, due.value, due.last, packet_byte, last_byte);
          end
        end
      end
      if (cmd_valid && !cmd_stall)
        frame_packet(opcode, joint_index, goal_angle, goal_speed);
    end
    pending = bytes_due.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the servo packet framer testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sipf_pkg::*;

  localparam int LONG_HOLD = 120;
  localparam int PHASE_ITEMS = 105;

  logic               clk;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_stall;
  logic               opcode;
  logic [2:0]         joint_index;
  logic signed [15:0] goal_angle;
  logic [15:0]        goal_speed;
  logic               pkt_valid;
  logic               pkt_stall;
  logic [7:0]         packet_byte;
  logic               last_byte;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [3:0]         cfg_data;
  int                 errors;
  int                 pending;

  int holds_asked = 0;
  int holds_done  = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  int reads_sent  = 0;
  int writes_sent = 0;
  int settings    = 0;

  servo_instruction_packet_framer_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .opcode      (opcode),
    .joint_index (joint_index),
    .goal_angle  (goal_angle),
    .goal_speed  (goal_speed),
    .pkt_valid   (pkt_valid),
    .pkt_stall   (pkt_stall),
    .packet_byte (packet_byte),
    .last_byte   (last_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  sipf_packet_checker #(.JOINT_SLOTS(8)) i_checker (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .opcode      (opcode),
    .joint_index (joint_index),
    .goal_angle  (goal_angle),
    .goal_speed  (goal_speed),
    .pkt_valid   (pkt_valid),
    .pkt_stall   (pkt_stall),
    .packet_byte (packet_byte),
    .last_byte   (last_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .pending     (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: changing stall pattern, with a long hold-off on request.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    pkt_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pkt_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 48);
        end
        mode_left--;
        case (mode)
          0: begin
            pkt_stall <= 1'b0;
          end
          1: begin
            pkt_stall <= ($urandom_range(0, 9) < 3);
          end
          2: begin
            pkt_stall <= ($urandom_range(0, 9) < 7);
          end
          default: begin
            pkt_stall <= ~pkt_stall;
          end
        endcase
      end
    end
  end

  // Enter and leave at a falling edge; hold valid across a burst.
  task automatic send_cmd(logic op, logic [2:0] joint, logic signed [15:0] angle,
                          logic [15:0] speed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    cmd_valid   <= 1'b1;
    opcode      <= op;
    joint_index <= joint;
    goal_angle  <= angle;
    goal_speed  <= speed;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    @(negedge clk);
    if (op == OP_READ) reads_sent++;
    else               writes_sent++;
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [3:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(logic [3:0] model2, logic [3:0] unused);
    write_reg(CFG_SECOND_MODEL, model2);
    write_reg(CFG_FIRST_UNUSED, unused);
    cfg_valid <= 1'b0;
    @(negedge clk);
    settings++;
  endtask

  task automatic send_random();
    logic signed [15:0] angle;
    case ($urandom_range(0, 3))
      0: angle = 16'($urandom);
      1: angle = -16'sd32768 + 16'($urandom_range(0, 63));
      2: angle = 16'sd32767 - 16'($urandom_range(0, 63));
      default: angle = 16'($urandom_range(0, 1023)) - 16'sd512;
    endcase
    send_cmd(($urandom_range(0, 9) < 7) ? OP_WRITE : OP_READ, 3'($urandom_range(0, 7)),
             angle, 16'($urandom));
  endtask

  initial begin
    int unused;
    rst         = 1'b1;
    cmd_valid   = 1'b0;
    opcode      = OP_READ;
    joint_index = 3'd0;
    goal_angle  = 16'sd0;
    goal_speed  = 16'd0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_SECOND_MODEL;
    cfg_data    = 4'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: joint 4 on the second scale, joints 5 and up unused
    send_cmd(OP_READ,  3'd0, 16'sd0,      16'h0000);
    send_cmd(OP_READ,  3'd7, -16'sd32768, 16'hFFFF);
    send_cmd(OP_WRITE, 3'd0, 16'sd0,      16'h0000);
    send_cmd(OP_WRITE, 3'd0, 16'sd32767,  16'hFFFF);
    send_cmd(OP_WRITE, 3'd0, -16'sd32768, 16'h1234);
    send_cmd(OP_WRITE, 3'd4, 16'sd32767,  16'hA5C3);
    send_cmd(OP_WRITE, 3'd4, -16'sd32768, 16'h00FF);
    send_cmd(OP_WRITE, 3'd5, 16'sd1000,   16'hFFFF);
    send_cmd(OP_WRITE, 3'd7, -16'sd1,     16'hFFFF);
    send_cmd(OP_WRITE, 3'd3, -16'sd1,     16'h8001);
    drain();
    // top bit of the joint select is dropped; all joints in use
    set_config(4'hF, 4'd8);
    send_cmd(OP_WRITE, 3'd7, 16'sd32767,  16'hFFFF);
    send_cmd(OP_WRITE, 3'd7, -16'sd32768, 16'h0001);
    send_cmd(OP_WRITE, 3'd6, 16'sd12345,  16'h5AA5);
    send_cmd(OP_READ,  3'd7, 16'sd4000,   16'h4321);
    drain();
    // every joint unused, including the second-scale one
    set_config(4'd0, 4'd0);
    send_cmd(OP_WRITE, 3'd0, 16'sd1111,   16'hFFFF);
    send_cmd(OP_WRITE, 3'd3, -16'sd5000,  16'h0001);
    drain();
    // above the joint count: every joint in use
    set_config(4'd2, 4'd15);
    send_cmd(OP_WRITE, 3'd7, -16'sd20000, 16'hBEEF);
    send_cmd(OP_WRITE, 3'd2, 16'sd20000,  16'hCAFE);
    send_cmd(OP_WRITE, 3'd1, -16'sd9,     16'h0007);
    send_cmd(OP_READ,  3'd2, 16'sd0,      16'h0000);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      unused = $urandom_range(0, 9);
      if (unused == 9) unused = $urandom_range(9, 15);
      set_config(4'($urandom_range(0, 15)), 4'(unused));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 30) begin
          // hold the byte lane off and keep offering items back to back
          holds_asked++;
          gaps_on = 1'b0;
        end
        if (phase == 1 && n == 60) gaps_on = 1'b1;
        if (phase == 2 && n == 50) drain();
        send_random();
      end
      drain();
    end

    repeat (40) @(negedge clk);
    $display("Sent %0d read and %0d write commands under %0d register settings,",
             reads_sent, writes_sent, settings + 1);
    $display("with sender gaps, receiver stalls and one long %0d-cycle hold-off.", LONG_HOLD);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/sipf_pkg.sv
hdl/sipf_scale.sv
hdl/sipf_packer.sv
hdl/sipf_serial.sv
hdl/servo_instruction_packet_framer_core.sv
tb/sv/sipf_packet_checker.sv
tb/sv/testbench.sv
